### hdl/lmp_pkg.sv
package lmp_pkg;

    // Header length in bytes (big-endian payload length)
    localparam int HDR_LEN = 2;

    localparam int OUT_DATA_W = 368;
    localparam int OUT_USER_W = 2;

    // ASCII type codes of the decoded messages
    localparam logic [7:0] TYPE_ADD        = 8'h41; // A
    localparam logic [7:0] TYPE_ADD_MPID   = 8'h46; // F
    localparam logic [7:0] TYPE_EXEC       = 8'h45; // E
    localparam logic [7:0] TYPE_EXEC_PRICE = 8'h43; // C
    localparam logic [7:0] TYPE_CANCEL     = 8'h58; // X
    localparam logic [7:0] TYPE_DELETE     = 8'h44; // D
    localparam logic [7:0] TYPE_REPLACE    = 8'h55; // U
    localparam logic [7:0] TYPE_TRADE      = 8'h50; // P
    localparam logic [7:0] TYPE_CROSS      = 8'h51; // Q
    localparam logic [7:0] TYPE_BROKEN     = 8'h42; // B

    typedef enum logic [1:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_STOPPED
    } t_phase;

    typedef struct packed {
        logic [15:0] locate;
        logic [47:0] time_stamp;
        logic [63:0] reference;
        logic [63:0] new_reference;
        logic [7:0]  side;
        logic [63:0] shares;
        logic [31:0] price;
    } t_caps;

    function automatic logic is_known(input logic [7:0] t);
        return t inside {TYPE_ADD, TYPE_ADD_MPID, TYPE_EXEC, TYPE_EXEC_PRICE, TYPE_CANCEL,
                         TYPE_DELETE, TYPE_REPLACE, TYPE_TRADE, TYPE_CROSS, TYPE_BROKEN};
    endfunction

endpackage

### hdl/length_prefixed_market_message_parser_top.sv
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata[7:0] feed_byte
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: message fields, tuser: flags
//
// One byte per clock while no result is held up: a byte is registered, then parsed and, on the
// last byte of a message, its result lands in the output register.
// Synchronous active-low reset returns the parser to the header state, clears the
// byte total and leaves session-end mode.
// A stalled output holds its result; input keeps flowing as long as no new result
// has to replace one still waiting.
module length_prefixed_market_message_parser_top
    import lmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] feed_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // msg_type[7:0], msg_length[23:8], stock_locate[39:24], time_stamp[87:40],
    // reference[151:88], new_reference[215:152], side[223:216], shares[287:224],
    // price[319:288], total_bytes[367:320]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // known_type[0], session_end[1]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    typedef struct packed {
        logic [7:0]  msg_type;
        logic        known_type;
        logic [15:0] msg_length;
        t_caps       caps;
        logic        session_end;
        logic [47:0] total_bytes;
    } t_result;

    // Input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_idx, n_idx;
    logic [7:0]  r_type, n_type;
    t_caps       r_caps, n_caps;
    logic [47:0] r_total, n_total;

    // Output stage
    logic        r_out_valid;
    t_result     r_out;

    logic        w_adv;
    logic        w_emit;
    logic        w_last;
    logic        w_known;
    t_result     w_res;
    t_caps       w_cap_next;

    // Only a byte that finishes a result has to wait for the output register
    assign w_adv         = r_in_valid && (!w_emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Type byte is at index zero; it is not a capture byte
    lmp_capture u_capture (
        .i_type (r_type),
        .i_idx  (r_idx),
        .i_byte (r_in_byte),
        .i_caps (r_caps),
        .o_caps (w_cap_next)
    );

    assign w_last = ({1'b0, r_idx} + 17'd1) >= {1'b0, r_len};

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_idx   = r_idx;
        n_type  = r_type;
        n_caps  = r_caps;
        n_total = r_total;
        case (r_phase)
            PH_LEN_HI: begin
                n_len   = {r_in_byte, 8'd0};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = {r_len[15:8], r_in_byte};
                if (n_len == 16'd0) begin
                    n_phase = PH_STOPPED;
                end else begin
                    n_phase = PH_PAYLOAD;
                    n_idx   = '0;
                    n_type  = '0;
                    n_caps  = '0;
                end
            end
            PH_PAYLOAD: begin
                if (r_idx == 16'd0) begin
                    n_type = r_in_byte;
                end else begin
                    n_caps = w_cap_next;
                end
                if (w_last) begin
                    n_phase = PH_LEN_HI;
                    n_total = r_total + 48'(HDR_LEN) + {32'd0, r_len};
                end else begin
                    n_idx = r_idx + 16'd1;
                end
            end
            PH_STOPPED: begin
                n_phase = PH_STOPPED;
            end
            default: begin
                n_phase = PH_LEN_HI;
            end
        endcase
    end

    // Result
    always_comb begin
        w_emit  = 1'b0;
        w_known = is_known(n_type);
        w_res   = '0;
        case (r_phase)
            PH_LEN_LO: begin
                if (r_in_byte == 8'd0 && r_len[15:8] == 8'd0) begin
                    w_emit            = 1'b1;
                    w_res.session_end = 1'b1;
                    w_res.total_bytes = r_total;
                end
            end
            PH_PAYLOAD: begin
                if (w_last) begin
                    w_emit            = 1'b1;
                    w_res.msg_type    = n_type;
                    w_res.known_type  = w_known;
                    w_res.msg_length  = r_len;
                    w_res.caps        = w_known ? n_caps : '0;
                    w_res.total_bytes = n_total;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_LEN_HI;
            r_len       <= '0;
            r_idx       <= '0;
            r_type      <= '0;
            r_total     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_idx   <= n_idx;
                r_type  <= n_type;
                r_total <= n_total;
            end
            if (w_adv && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_adv) begin
            r_caps <= n_caps;
        end
        if (w_adv && w_emit) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.total_bytes, r_out.caps.price, r_out.caps.shares,
                            r_out.caps.side, r_out.caps.new_reference,
                            r_out.caps.reference, r_out.caps.time_stamp,
                            r_out.caps.locate, r_out.msg_length, r_out.msg_type};
    assign m_axis_tuser  = {r_out.session_end, r_out.known_type};

    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.session_end) |-> (r_phase == PH_STOPPED))
        else $error("session-end result without stopped parser");

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOPPED) |=> (r_phase == PH_STOPPED))
        else $error("parser left stopped state without reset");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_len != 16'd0 && r_idx < r_len))
        else $error("payload index outside message length");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a blocked result");

endmodule

### hdl/lmp_capture.sv
module lmp_capture
    import lmp_pkg::*;
(
    input  logic [7:0]  i_type,
    input  logic [15:0] i_idx,
    input  logic [7:0]  i_byte,
    input  t_caps       i_caps,
    output t_caps       o_caps
);

    // Drop byte b into its big-endian lane if idx falls in [off, off+len)
    function automatic logic [63:0] put(input logic [63:0] cap, input logic [15:0] idx,
                                        input int off, input int len, input logic [7:0] b);
        logic [63:0] r;
        r = cap;
        for (int k = 0; k < 8; k++) begin
            if (k < len && idx == 16'(off + k)) begin
                r[8 * (len - 1 - k) +: 8] = b;
            end
        end
        return r;
    endfunction

    logic [63:0] w_loc, w_tim, w_ref, w_nref, w_side, w_shr, w_prc;

    always_comb begin
        w_loc  = {48'd0, i_caps.locate};
        w_tim  = {16'd0, i_caps.time_stamp};
        w_ref  = i_caps.reference;
        w_nref = i_caps.new_reference;
        w_side = {56'd0, i_caps.side};
        w_shr  = i_caps.shares;
        w_prc  = {32'd0, i_caps.price};

        w_loc = put(w_loc, i_idx, 1, 2, i_byte);
        w_tim = put(w_tim, i_idx, 5, 6, i_byte);

        if (i_type inside {TYPE_ADD, TYPE_ADD_MPID, TYPE_TRADE}) begin
            w_ref  = put(w_ref, i_idx, 11, 8, i_byte);
            w_side = put(w_side, i_idx, 19, 1, i_byte);
            w_shr  = put(w_shr, i_idx, 20, 4, i_byte);
            w_prc  = put(w_prc, i_idx, 32, 4, i_byte);
        end else if (i_type inside {TYPE_EXEC, TYPE_EXEC_PRICE, TYPE_CANCEL}) begin
            w_ref = put(w_ref, i_idx, 11, 8, i_byte);
            w_shr = put(w_shr, i_idx, 19, 4, i_byte);
            if (i_type == TYPE_EXEC_PRICE) begin
                w_prc = put(w_prc, i_idx, 32, 4, i_byte);
            end
        end else if (i_type inside {TYPE_DELETE, TYPE_BROKEN}) begin
            w_ref = put(w_ref, i_idx, 11, 8, i_byte);
        end else if (i_type == TYPE_REPLACE) begin
            w_ref  = put(w_ref, i_idx, 11, 8, i_byte);
            w_nref = put(w_nref, i_idx, 19, 8, i_byte);
            w_shr  = put(w_shr, i_idx, 27, 4, i_byte);
            w_prc  = put(w_prc, i_idx, 31, 4, i_byte);
        end else if (i_type == TYPE_CROSS) begin
            w_shr = put(w_shr, i_idx, 11, 8, i_byte);
            w_prc = put(w_prc, i_idx, 27, 4, i_byte);
        end
    end

    assign o_caps.locate        = w_loc[15:0];
    assign o_caps.time_stamp    = w_tim[47:0];
    assign o_caps.reference     = w_ref;
    assign o_caps.new_reference = w_nref;
    assign o_caps.side          = w_side[7:0];
    assign o_caps.shares        = w_shr;
    assign o_caps.price         = w_prc[31:0];

endmodule

### dv/tb_top.sv
import lmp_pkg::*;

// One expected or observed message result, fields at their port widths.
typedef struct packed {
    logic [7:0]  msg_type;
    logic        known;
    logic [15:0] msg_length;
    logic [15:0] locate;
    logic [47:0] stamp;
    logic [63:0] order_ref;
    logic [63:0] new_ref;
    logic [7:0]  side;
    logic [63:0] shares;
    logic [31:0] price;
    logic        sess_end;
    logic [47:0] total;
} t_feed_result;

// Tracks the parser state byte by byte and keeps the results still owed by the DUT.
class parse_scoreboard;
    t_feed_result due_results[$];
    int errors;
    int checked;
    int unknown_seen;
    int bytes_fed;

    logic [16:0] pos;
    logic [15:0] plen;
    logic [7:0]  tcode;
    logic [63:0] c_loc, c_ts, c_ref, c_nref, c_side, c_shr, c_px;
    logic [47:0] total;
    bit          halted;

    function new();
        errors = 0;
        checked = 0;
        unknown_seen = 0;
        bytes_fed = 0;
        pos = '0;
        plen = '0;
        total = '0;
        halted = 1'b0;
        clear_caps();
    endfunction

    function void clear_caps();
        tcode = '0;
        c_loc = '0;
        c_ts = '0;
        c_ref = '0;
        c_nref = '0;
        c_side = '0;
        c_shr = '0;
        c_px = '0;
    endfunction

    function bit decoded(logic [7:0] t);
        case (t)
            TYPE_ADD, TYPE_ADD_MPID, TYPE_EXEC, TYPE_EXEC_PRICE, TYPE_CANCEL,
            TYPE_DELETE, TYPE_REPLACE, TYPE_TRADE, TYPE_CROSS, TYPE_BROKEN: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Drop byte b into a big-endian field spanning payload bytes [off, off+len).
    function logic [63:0] lay(logic [63:0] acc, int idx, int off, int len, logic [7:0] b);
        logic [63:0] wide;
        wide = {56'd0, b};
        if (idx >= off && idx < off + len)
            acc = acc | (wide << (8 * (off + len - 1 - idx)));
        return acc;
    endfunction

    function void grab(int idx, logic [7:0] b);
        c_loc = lay(c_loc, idx, 1, 2, b);
        c_ts  = lay(c_ts, idx, 5, 6, b);
        case (tcode)
            TYPE_ADD, TYPE_ADD_MPID, TYPE_TRADE: begin
                c_ref  = lay(c_ref, idx, 11, 8, b);
                c_side = lay(c_side, idx, 19, 1, b);
                c_shr  = lay(c_shr, idx, 20, 4, b);
                c_px   = lay(c_px, idx, 32, 4, b);
            end
            TYPE_EXEC, TYPE_EXEC_PRICE, TYPE_CANCEL: begin
                c_ref = lay(c_ref, idx, 11, 8, b);
                c_shr = lay(c_shr, idx, 19, 4, b);
                if (tcode == TYPE_EXEC_PRICE)
                    c_px = lay(c_px, idx, 32, 4, b);
            end
            TYPE_DELETE, TYPE_BROKEN: begin
                c_ref = lay(c_ref, idx, 11, 8, b);
            end
            TYPE_REPLACE: begin
                c_ref  = lay(c_ref, idx, 11, 8, b);
                c_nref = lay(c_nref, idx, 19, 8, b);
                c_shr  = lay(c_shr, idx, 27, 4, b);
                c_px   = lay(c_px, idx, 31, 4, b);
            end
            TYPE_CROSS: begin
                c_shr = lay(c_shr, idx, 11, 8, b);
                c_px  = lay(c_px, idx, 27, 4, b);
            end
            default: ;
        endcase
    endfunction

    // Called for every accepted feed byte.
    function void take_byte(logic [7:0] b);
        int idx;
        t_feed_result r;
        bytes_fed++;
        if (halted)
            return;
        if (pos == 17'd0) begin
            plen = {b, 8'h00};
            pos = 17'd1;
        end else if (pos == 17'd1) begin
            plen[7:0] = b;
            if (plen == 16'd0) begin
                // session end: no header bytes counted, parser goes inert
                halted = 1'b1;
                pos = '0;
                r = '0;
                r.sess_end = 1'b1;
                r.total = total;
                due_results.push_back(r);
            end else begin
                clear_caps();
                pos = 17'd2;
            end
        end else begin
            idx = int'(pos) - HDR_LEN;
            if (idx == 0)
                tcode = b;
            else
                grab(idx, b);
            if (idx + 1 < int'(plen)) begin
                pos = pos + 17'd1;
            end else begin
                pos = '0;
                total = total + 48'(HDR_LEN) + 48'(plen);
                r = '0;
                r.msg_type = tcode;
                r.known = decoded(tcode);
                r.msg_length = plen;
                if (r.known) begin
                    r.locate = c_loc[15:0];
                    r.stamp = c_ts[47:0];
                    r.order_ref = c_ref;
                    r.new_ref = c_nref;
                    r.side = c_side[7:0];
                    r.shares = c_shr;
                    r.price = c_px[31:0];
                end
                r.total = total;
                due_results.push_back(r);
            end
        end
    endfunction

    function string show(t_feed_result r);
        string head;
        string tail;
        head = $sformatf("type=%h known=%b len=%h loc=%h ts=%h ref=%h ",
                         r.msg_type, r.known, r.msg_length, r.locate, r.stamp, r.order_ref);
        tail = $sformatf("nref=%h side=%h shr=%h px=%h end=%b tot=%h",
                         r.new_ref, r.side, r.shares, r.price, r.sess_end, r.total);
        return {head, tail};
    endfunction

    // Called for every result taken off the output stream.
    function void match_result(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
        t_feed_result got;
        t_feed_result want;
        string bad;
        got.msg_type   = d[7:0];
        got.msg_length = d[23:8];
        got.locate     = d[39:24];
        got.stamp      = d[87:40];
        got.order_ref  = d[151:88];
        got.new_ref    = d[215:152];
        got.side       = d[223:216];
        got.shares     = d[287:224];
        got.price      = d[319:288];
        got.total      = d[367:320];
        got.known      = u[0];
        got.sess_end   = u[1];
        if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: %s", show(got));
            return;
        end
        want = due_results.pop_front();
        checked++;
        if (!want.known && !want.sess_end)
            unknown_seen++;
        bad = "";
        if (got.msg_type   !== want.msg_type)   bad = {bad, " msg_type"};
        if (got.known      !== want.known)      bad = {bad, " known_type"};
        if (got.msg_length !== want.msg_length) bad = {bad, " msg_length"};
        if (got.locate     !== want.locate)     bad = {bad, " stock_locate"};
        if (got.stamp      !== want.stamp)      bad = {bad, " time_stamp"};
        if (got.order_ref  !== want.order_ref)  bad = {bad, " reference"};
        if (got.new_ref    !== want.new_ref)    bad = {bad, " new_reference"};
        if (got.side       !== want.side)       bad = {bad, " side"};
        if (got.shares     !== want.shares)     bad = {bad, " shares"};
        if (got.price      !== want.price)      bad = {bad, " price"};
        if (got.sess_end   !== want.sess_end)   bad = {bad, " session_end"};
        if (got.total      !== want.total)      bad = {bad, " total_bytes"};
        if (bad != "") begin
            errors++;
            if (errors <= 10) begin
                $display("result %0d mismatch on%s", checked, bad);
                $display("  expected %s", show(want));
                $display("  actual   %s", show(got));
            end
        end
    endfunction
endclass

module tb_top;

    typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} t_fill;

    // Type codes outside the decoded set, used for the unknown-type cases
    localparam logic [7:0] KIND_SYSTEM = 8'h53;
    localparam logic [7:0] KIND_NULL   = 8'h00;
    localparam logic [7:0] KIND_HIGH   = 8'hFF;

    localparam logic [7:0] KINDS [10] = '{TYPE_ADD, TYPE_ADD_MPID, TYPE_EXEC, TYPE_EXEC_PRICE,
                                          TYPE_CANCEL, TYPE_DELETE, TYPE_REPLACE, TYPE_TRADE,
                                          TYPE_CROSS, TYPE_BROKEN};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'h00;   // [7:0] feed_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // msg_type, msg_length, stock_locate, time_stamp, reference, new_reference,
    // side, shares, price, total_bytes (lowest first)
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // known_type, session_end (lowest first)
    logic [OUT_USER_W-1:0] m_axis_tuser;

    parse_scoreboard sb;

    // Traffic shaping knobs shared by the sender and the receiver
    bit calm = 1'b0;          // tail of the run: no idling on either side
    bit pressing = 1'b0;      // sender runs flat out while the receiver is held
    bit squeeze_go = 1'b0;    // kicks off the long receiver hold
    logic hold_rx = 1'b0;     // receiver held off by the pressure process
    int tx_odds = 0;          // percent chance of a sender gap before a byte

    always #6 i_clk = ~i_clk;

    length_prefixed_market_message_parser_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Nominal message lengths of the decoded types; random for anything else.
    function automatic int std_len(input logic [7:0] kind);
        case (kind)
            TYPE_ADD:        return 36;
            TYPE_ADD_MPID:   return 40;
            TYPE_EXEC:       return 31;
            TYPE_EXEC_PRICE: return 36;
            TYPE_CANCEL:     return 23;
            TYPE_DELETE:     return 19;
            TYPE_REPLACE:    return 35;
            TYPE_TRADE:      return 44;
            TYPE_CROSS:      return 40;
            TYPE_BROKEN:     return 19;
            default:         return $urandom_range(1, 48);
        endcase
    endfunction

    // Offer one byte and hold it until the parser takes it. An idle burst may
    // come first; valid is never dropped between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        if (!calm && !pressing && tx_odds != 0 && $urandom_range(1, 100) <= tx_odds) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.take_byte(b);
    endtask

    // Two-byte big-endian length, the type byte, then the rest of the payload.
    task automatic send_msg(input int len, input logic [7:0] kind, input t_fill fill);
        int k;
        logic [15:0] hdr;
        logic [31:0] rnd;
        logic [7:0] pb;
        hdr = len[15:0];
        // gap density changes per message: none, sparse or dense
        case ($urandom_range(0, 2))
            0: tx_odds = 0;
            1: tx_odds = 8;
            default: tx_odds = 35;
        endcase
        send_byte(hdr[15:8]);
        send_byte(hdr[7:0]);
        for (k = 0; k < len; k++) begin
            rnd = $urandom;
            case (fill)
                FILL_ZERO: pb = 8'h00;
                FILL_ONES: pb = 8'hFF;
                default:   pb = rnd[7:0];
            endcase
            send_byte(k == 0 ? kind : pb);
        end
    endtask

    // A well-formed-ish random message: mostly decoded types at their nominal
    // length, some truncated or overlong, a few unknown types and odd fills.
    task automatic send_random_msg();
        logic [31:0] rnd;
        logic [7:0] kind;
        int len;
        int roll;
        t_fill fill;
        rnd = $urandom;
        kind = ($urandom_range(0, 99) < 80) ? KINDS[$urandom_range(0, 9)] : rnd[15:8];
        roll = $urandom_range(0, 99);
        if (roll < 60)
            len = std_len(kind);
        else if (roll < 85)
            len = $urandom_range(1, 50);
        else if (roll < 97)
            len = $urandom_range(1, 12);
        else
            len = $urandom_range(256, 400);
        roll = $urandom_range(0, 99);
        fill = (roll < 5) ? FILL_ZERO : (roll < 10) ? FILL_ONES : FILL_RAND;
        send_msg(len, kind, fill);
    endtask

    // Result sink: checks every accepted result and stalls in random bursts.
    initial begin
        int gap_left;
        int rx_pct;
        int tick;
        gap_left = 0;
        rx_pct = 10;
        tick = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.match_result(m_axis_tdata, m_axis_tuser);
            tick++;
            if (tick % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0: rx_pct = 0;
                    1: rx_pct = 10;
                    default: rx_pct = 30;
                endcase
            end
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm && rx_pct != 0 && $urandom_range(1, 100) <= rx_pct) begin
                gap_left = $urandom_range(1, 11) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so results back up and the parser stalls its input.
    initial begin
        wait (squeeze_go);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Main sequence
    initial begin
        int k;
        logic [31:0] rnd;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every decoded type at its nominal length, two with flat fills
        send_msg(36, TYPE_ADD, FILL_RAND);
        send_msg(40, TYPE_ADD_MPID, FILL_RAND);
        send_msg(31, TYPE_EXEC, FILL_RAND);
        send_msg(36, TYPE_EXEC_PRICE, FILL_RAND);
        send_msg(23, TYPE_CANCEL, FILL_RAND);
        send_msg(19, TYPE_DELETE, FILL_RAND);
        send_msg(35, TYPE_REPLACE, FILL_ONES);
        send_msg(44, TYPE_TRADE, FILL_ZERO);
        send_msg(40, TYPE_CROSS, FILL_RAND);
        send_msg(19, TYPE_BROKEN, FILL_RAND);
        // unknown types report only type, length and running total
        send_msg(12, KIND_SYSTEM, FILL_RAND);
        send_msg(40, KIND_HIGH, FILL_ONES);
        send_msg(3, KIND_NULL, FILL_RAND);
        // short messages: fields cut off mid-way keep their partial bytes
        send_msg(1, TYPE_ADD, FILL_RAND);
        send_msg(2, TYPE_EXEC, FILL_ONES);
        send_msg(15, TYPE_ADD, FILL_ONES);
        send_msg(22, TYPE_REPLACE, FILL_RAND);
        send_msg(29, TYPE_CROSS, FILL_RAND);
        send_msg(34, TYPE_EXEC_PRICE, FILL_ONES);
        // long messages: trailing bytes ignored, one with a nonzero length high byte
        send_msg(60, TYPE_TRADE, FILL_RAND);
        send_msg(256, TYPE_BROKEN, FILL_RAND);

        // random traffic with idling on both sides
        while (sb.bytes_fed < 1250)
            send_random_msg();

        // back pressure: tiny messages flood in while the sink is held off
        pressing = 1'b1;
        squeeze_go = 1'b1;
        for (k = 0; k < 80; k++)
            send_msg($urandom_range(1, 3), KINDS[$urandom_range(0, 9)], FILL_RAND);
        pressing = 1'b0;

        // tail with no idling, then the session-end header and a few dead bytes
        calm = 1'b1;
        while (sb.bytes_fed < 1840)
            send_random_msg();
        send_byte(8'h00);
        send_byte(8'h00);
        for (k = 0; k < 6; k++) begin
            rnd = $urandom;
            send_byte(rnd[7:0]);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then leave room for a stray result to show up
        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Fed %0d bytes; %0d results checked, %0d of unknown type, ending on session end.",
                 sb.bytes_fed, sb.checked, sb.unknown_seen);
        $display("Mismatches or unexpected results: %0d", sb.errors);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("timeout with %0d results still owed", sb.due_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
